// ===== hdl/swsc_pkg.sv =====
// Shared constants, types and a helper function for the SFR write stream classifier.
package swsc_pkg;

  // Table geometry; SECTORS_PER_CHUNK must be a power of two
  localparam int CHUNK_ENTRIES     = 4096;
  localparam int SECTORS_PER_CHUNK = 4096;
  localparam int CHUNK_W           = $clog2(CHUNK_ENTRIES);
  localparam int SPC_SHIFT         = $clog2(SECTORS_PER_CHUNK);

  // Field widths
  localparam int SECTOR_W = 48;
  localparam int LEN_W    = 32;
  localparam int TIME_W   = 48;
  localparam int CNT_W    = 32;
  localparam int SID_W    = 4;
  localparam int CIU_W    = 13;
  localparam int PERIOD_W = 32;
  localparam int CHUNK_NUM_W = SECTOR_W - SPC_SHIFT;

  // Saturated quotient of elapsed time over the decay period
  localparam int QUO_W = 7;
  localparam int DVS_W = PERIOD_W + QUO_W - 1;

  // Configuration register indexes
  localparam logic CFG_CHUNKS_IN_USE = 1'b0;
  localparam logic CFG_DECAY_PERIOD  = 1'b1;

  localparam logic [CIU_W-1:0]    CIU_RESET    = CIU_W'(4096);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(30000000);

  // One table entry
  typedef struct packed {
    logic [SID_W-1:0]  sid;
    logic [TIME_W-1:0] last;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

  typedef logic [CNT_W-1:0] decade_bounds_t [8];
  localparam decade_bounds_t DECADE_BOUNDS = '{
    32'd10, 32'd100, 32'd1000, 32'd10000,
    32'd100000, 32'd1000000, 32'd10000000, 32'd100000000
  };

  // Decimal decade of a count, 0 to 8: bounds rise, so count those passed
  function automatic logic [SID_W-1:0] decade_of(input logic [CNT_W-1:0] c);
    logic [SID_W-1:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) begin
      if (c >= DECADE_BOUNDS[i]) begin
        d = d + SID_W'(1);
      end
    end
    return d;
  endfunction

endpackage

// ===== hdl/sfr_write_stream_classifier.sv =====
// Top level of the SFR write stream classifier: sequencer, chunk table and shared divider.
// An accepted request runs through ST_PREP, the 7-step restoring divider that counts elapsed
// decay periods when the entry decays, ST_SHIFT, ST_WRITE and ST_DONE; a chunk out of range
// goes straight to ST_DONE. ST_DONE waits until the output register is free, and s_tready
// stays low while a request is held, so a new request is taken only after the last is done.
// Reset (rst, synchronous): clears control state, then a clearing pass over all
// CHUNK_ENTRIES (4096) entries zeroes the chunk table while s_tready is low.
module sfr_write_stream_classifier
  import swsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // start_sector [47:0], length_sectors [79:48], now_us [127:80]
  input  logic [127:0]        s_tdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  // stream_id [3:0], sequential_hit [4], out_of_range [5], zero [7:6]
  output logic [7:0]          m_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_DIV, ST_SHIFT, ST_WRITE, ST_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [CIU_W-1:0]    chunks_in_use;
  logic [PERIOD_W-1:0] period_len;

  // Request held during processing
  logic [SECTOR_W-1:0] in_start;
  logic [LEN_W-1:0]    in_len;
  logic [TIME_W-1:0]   in_now;
  logic [CHUNK_W-1:0]  chunk_idx;

  // Sequence state
  logic [SECTOR_W:0]   prev_end;
  logic [SID_W-1:0]    prev_stream;
  logic [CHUNK_W-1:0]  clr_idx;

  // Working registers of the shared divider and count path
  logic [CNT_W-1:0]    cnt;
  logic [TIME_W-1:0]   rem;
  logic [DVS_W-1:0]    dvs;
  logic [QUO_W-1:0]    quo;
  logic [2:0]          div_k;

  // Result held until the output register is free
  logic [SID_W-1:0]    res_sid;
  logic                res_hit;
  logic                res_oor;
  logic [SID_W-1:0]    out_sid;
  logic                out_hit;
  logic                out_oor;

  // Chunk table
  entry_t              table_mem [CHUNK_ENTRIES];
  entry_t              rd_word;
  logic                mem_we;
  logic [CHUNK_W-1:0]  mem_waddr;
  entry_t              mem_wdata;

  // Input field decode
  logic [SECTOR_W-1:0]    s_start;
  logic [LEN_W-1:0]       s_len;
  logic [TIME_W-1:0]      s_now;
  logic [CHUNK_NUM_W-1:0] s_chunk;
  logic                   s_oor;
  logic                   accept;

  assign s_start = s_tdata[SECTOR_W-1:0];
  assign s_len   = s_tdata[SECTOR_W +: LEN_W];
  assign s_now   = s_tdata[SECTOR_W+LEN_W +: TIME_W];
  assign s_chunk = s_start[SECTOR_W-1:SPC_SHIFT];
  assign s_oor   = (s_chunk >= CHUNK_NUM_W'(CHUNK_ENTRIES)) ||
                   (s_chunk >= CHUNK_NUM_W'(chunks_in_use));
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = {2'b00, out_oor, out_hit, out_sid};

  // Decay decision on the entry just read
  logic             decay_ok;
  logic [CNT_W-1:0] cnt_inc;
  logic             div_ge;

  assign decay_ok = (rd_word.last != '0) && (period_len != '0) && (in_now > rd_word.last);
  assign cnt_inc  = (&rd_word.cnt) ? rd_word.cnt : rd_word.cnt + CNT_W'(1);
  assign div_ge   = rem >= TIME_W'(dvs);

  // Table write port: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chunk_idx;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      ST_WRITE: begin
        mem_we         = 1'b1;
        mem_wdata.sid  = decade_of(cnt);
        mem_wdata.last = in_now;
        mem_wdata.cnt  = cnt;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_word <= table_mem[s_start[SPC_SHIFT +: CHUNK_W]];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_in_use <= CIU_RESET;
      period_len    <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNKS_IN_USE: chunks_in_use <= cfg_data[CIU_W-1:0];
        CFG_DECAY_PERIOD:  period_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      prev_end    <= '0;
      prev_stream <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // Result register: loaded from the held result, dropped once taken
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + CHUNK_W'(1);
          if (clr_idx == CHUNK_W'(CHUNK_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            in_start  <= s_start;
            in_len    <= s_len;
            in_now    <= s_now;
            chunk_idx <= s_start[SPC_SHIFT +: CHUNK_W];
            res_hit   <= !s_oor && ({1'b0, s_start} == prev_end);
            res_oor   <= s_oor;
            res_sid   <= '0;
            state     <= s_oor ? ST_DONE : ST_PREP;
          end
        end
        ST_PREP: begin
          res_sid     <= res_hit ? prev_stream : rd_word.sid;
          prev_stream <= res_hit ? prev_stream : rd_word.sid;
          prev_end    <= {1'b0, in_start} + (SECTOR_W+1)'(in_len);
          cnt         <= cnt_inc;
          rem         <= in_now - rd_word.last;
          dvs         <= {period_len, (QUO_W-1)'(0)};
          quo         <= '0;
          div_k       <= 3'(QUO_W - 1);
          state       <= decay_ok ? ST_DIV : ST_SHIFT;
        end
        // One restoring step a cycle: exact below 128 periods, all ones beyond
        ST_DIV: begin
          if (div_ge) begin
            rem <= rem - TIME_W'(dvs);
          end
          quo <= {quo[QUO_W-2:0], div_ge};
          dvs <= dvs >> 1;
          div_k <= div_k - 3'd1;
          if (div_k == 3'd0) begin
            state <= ST_SHIFT;
          end
        end
        // 32 or more periods empties a 32-bit count
        ST_SHIFT: begin
          if (quo[QUO_W-1:5] != '0) begin
            cnt <= '0;
          end else begin
            cnt <= cnt >> quo[4:0];
          end
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_sid  <= res_sid;
            out_hit  <= res_hit;
            out_oor  <= res_oor;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/swsc_checker.sv =====
// Port-level checks for the SFR write stream classifier, bound to the top level.
module swsc_port_checks (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [7:0]          m_tdata,
  input logic                m_tvalid,
  input logic                m_tready
);

  // Reset starts the clearing pass with nothing in flight
  a_reset_quiet: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("busy or valid output right after reset");

  // One request at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a request is in progress");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // Out of range result carries no id and no hit
  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5]) |-> (m_tdata[4:0] == 5'd0))
    else $error("out of range result with id or hit");

  // Ids are decades 0 to 8, padding bits zero
  a_sid_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[3:0] <= 4'd8) && (m_tdata[7:6] == 2'b00)))
    else $error("stream id out of range");

endmodule

bind sfr_write_stream_classifier swsc_port_checks u_swsc_port_checks (.*);
